### rtl/core/ascs_pkg.sv
// ----------------------------------------------------------------------------
// ascs_pkg
// Shared types and constants of the step cadence and speed block.
// ----------------------------------------------------------------------------
package ascs_pkg;

  localparam int AXIS_BITS_DEF   = 12;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 12;
  localparam int GAP_W      = 16;
  localparam int TICK_W     = 32;
  localparam int SPEED_W    = 7;

  // instantaneous speed = SPEED_NUM / interval, capped at SPEED_MAX
  localparam int SPEED_NUM = 18000;
  localparam int SPEED_MAX = 99;
  localparam int NUM_W     = $clog2(SPEED_NUM + 1);
  // at or below this interval the quotient reaches the cap
  localparam int SAT_GAP   = SPEED_NUM / (SPEED_MAX + 1);

  // baseline tracks by difference / 2**BASE_SHIFT
  localparam int BASE_SHIFT = 5;

  // x / 5 == (x * 205) >> 10 for x below 1024
  localparam int DIV5_MUL   = 205;
  localparam int DIV5_MUL_W = 8;
  localparam int DIV5_SHIFT = 10;

  localparam logic              SENSOR_PRESENT_RST = 1'b1;
  localparam logic [THR_W-1:0]  STEP_THR_RST       = 12'd300;
  localparam logic [THR_W-1:0]  RELEASE_THR_RST    = 12'd150;
  localparam logic [GAP_W-1:0]  MIN_GAP_RST        = 16'd250;
  localparam logic [GAP_W-1:0]  STOP_GAP_RST       = 16'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_PRESENT = 3'd0,
    CFG_STEP_THR       = 3'd1,
    CFG_RELEASE_THR    = 3'd2,
    CFG_MIN_GAP        = 3'd3,
    CFG_STOP_GAP       = 3'd4
  } ascs_cfg_idx_t;

  typedef struct packed {
    logic             sensor_present;
    logic [THR_W-1:0] step_thr;
    logic [THR_W-1:0] release_thr;
    logic [GAP_W-1:0] min_gap;
    logic [GAP_W-1:0] stop_gap;
  } ascs_cfg_t;

  typedef enum logic {
    KIND_ZERO    = 1'b0,
    KIND_MEASURE = 1'b1
  } ascs_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DETECT,
    ST_DIVIDE,
    ST_SMOOTH,
    ST_EMIT
  } ascs_state_t;

endpackage

### rtl/core/ascs_if.sv
// ----------------------------------------------------------------------------
// ascs_if
// Valid/ready channels: sample input, speed result and register writes.
// ----------------------------------------------------------------------------
interface ascs_in_if import ascs_pkg::*; #(
  parameter int AXIS_BITS = AXIS_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [AXIS_BITS-1:0] accel_x;
  logic signed [AXIS_BITS-1:0] accel_y;
  logic signed [AXIS_BITS-1:0] accel_z;
  logic                        sample_ok;
  logic [TICK_W-1:0]           now_ms;

  modport source (output valid, accel_x, accel_y, accel_z, sample_ok, now_ms,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, sample_ok, now_ms,
                  output ready);
endinterface

interface ascs_out_if import ascs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed;

  modport source (output valid, speed, input ready);
  modport sink   (input valid, speed, output ready);
endinterface

interface ascs_cfg_if import ascs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/ascs_front.sv
// ----------------------------------------------------------------------------
// ascs_front
// Register file and intake: tags each sample word as measured or zero.
// ----------------------------------------------------------------------------
module ascs_front import ascs_pkg::*; #(
  parameter int AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ascs_in_if.sink                              in_chan,
  ascs_cfg_if.sink                             cfg_chan,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output logic [1+3*AXIS_BITS+TICK_W-1:0]      push_data,
  output ascs_cfg_t                            cfg
);

  ascs_cfg_t  cfg_r, cfg_nxt;
  ascs_kind_t kind;

  assign cfg_chan.ready = 1'b1;
  assign cfg            = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (ascs_cfg_idx_t'(cfg_chan.index))
        CFG_SENSOR_PRESENT: cfg_nxt.sensor_present = cfg_chan.data[0];
        CFG_STEP_THR:       cfg_nxt.step_thr       = cfg_chan.data[THR_W-1:0];
        CFG_RELEASE_THR:    cfg_nxt.release_thr    = cfg_chan.data[THR_W-1:0];
        CFG_MIN_GAP:        cfg_nxt.min_gap        = cfg_chan.data[GAP_W-1:0];
        CFG_STOP_GAP:       cfg_nxt.stop_gap       = cfg_chan.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_present <= SENSOR_PRESENT_RST;
      cfg_r.step_thr       <= STEP_THR_RST;
      cfg_r.release_thr    <= RELEASE_THR_RST;
      cfg_r.min_gap        <= MIN_GAP_RST;
      cfg_r.stop_gap       <= STOP_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // absent sensor or failed read: answered zero, touches no state
  always_comb begin
    kind = (cfg_r.sensor_present && in_chan.sample_ok) ? KIND_MEASURE : KIND_ZERO;
  end

  assign push_valid    = in_chan.valid;
  assign in_chan.ready = push_ready;
  assign push_data     = {kind, in_chan.accel_x, in_chan.accel_y, in_chan.accel_z,
                          in_chan.now_ms};

endmodule

### rtl/core/ascs_queue.sv
// ----------------------------------------------------------------------------
// ascs_queue
// Small register FIFO between intake and the processing engine.
// ----------------------------------------------------------------------------
module ascs_queue import ascs_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/ascs_back.sv
// ----------------------------------------------------------------------------
// ascs_back
// Engine: shared-multiplier sum of squares, bitwise root, step detector,
// restoring divider, smoothing and the result register.
// ----------------------------------------------------------------------------
module ascs_back import ascs_pkg::*; #(
  parameter int AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  logic [1+3*AXIS_BITS+TICK_W-1:0]      pop_data,
  input  ascs_cfg_t                            cfg,
  ascs_out_if.source                           out_chan
);

  localparam int A         = AXIS_BITS;
  localparam int ENTRY_W   = 1 + 3*A + TICK_W;
  localparam int SUM_W     = 2*A;
  localparam int REM_W     = A + 2;
  localparam int STEPS_MAX = (A > NUM_W) ? A : NUM_W;
  localparam int CNT_W     = $clog2(STEPS_MAX + 1);
  localparam int CMP_W     = (A > THR_W) ? A : THR_W;
  localparam int ACC_W     = SPEED_W + 2;
  localparam int PROD_W    = ACC_W + DIV5_MUL_W;

  ascs_state_t st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // item
  logic signed [A-1:0] ax_r, ay_r, az_r, ax_nxt, ay_nxt, az_nxt;
  logic [TICK_W-1:0]   now_r, now_nxt;

  // datapath
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [A-1:0]       root_r, root_nxt;
  logic [GAP_W-1:0]   gap_r, gap_nxt;
  logic [NUM_W-1:0]   dvd_r, dvd_nxt;
  logic [GAP_W-1:0]   drem_r, drem_nxt;
  logic [SPEED_W-1:0] inst_r, inst_nxt;
  logic [SPEED_W-1:0] result_r, result_nxt;
  logic               upd_r, upd_nxt, first_r, first_nxt, kill_r, kill_nxt;

  // detector state
  logic [A-1:0]       base_r, base_nxt;
  logic               base_valid_r, base_valid_nxt;
  logic               in_step_r, in_step_nxt;
  logic               had_step_r, had_step_nxt;
  logic [TICK_W-1:0]  last_r, last_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0] out_speed_r, out_speed_nxt;

  // combinational helpers
  ascs_kind_t            pop_kind;
  logic signed [A-1:0]   op;
  logic signed [SUM_W-1:0] sq;
  logic [REM_W+1:0]      rem_t, trial;
  logic signed [A:0]     diff, diff_adj, base_step, base_sum, dev_full;
  logic [A-1:0]          dev;
  logic [CMP_W-1:0]      dev_c, step_c, rel_c;
  logic [TICK_W-1:0]     gap;
  logic                  start, release_hit, in_window;
  logic [GAP_W:0]        drem_t;
  logic                  q_bit;
  logic [ACC_W-1:0]      acc;
  logic [PROD_W-1:0]     prod;
  logic [SPEED_W-1:0]    smooth_q, speed_new;

  assign pop_kind = ascs_kind_t'(pop_data[ENTRY_W-1]);

  // one multiplier, one axis per cycle
  always_comb begin
    if (cnt_r == CNT_W'(0)) begin
      op = ax_r;
    end else if (cnt_r == CNT_W'(1)) begin
      op = ay_r;
    end else begin
      op = az_r;
    end
  end
  assign sq = op * op;

  // two radicand bits per root step
  assign rem_t = {rem_r, sum_r[SUM_W-1 -: 2]};
  assign trial = {{(REM_W - A){1'b0}}, root_r, 2'b01};

  // baseline moves by diff/32 rounded toward zero
  assign diff      = $signed({1'b0, root_r}) - $signed({1'b0, base_r});
  assign diff_adj  = diff[A] ? diff + $signed({{(A + 1 - BASE_SHIFT){1'b0}},
                                               {BASE_SHIFT{1'b1}}})
                             : diff;
  assign base_step = diff_adj >>> BASE_SHIFT;
  assign base_sum  = $signed({1'b0, base_r}) + base_step;
  assign dev_full  = diff[A] ? -diff : diff;
  assign dev       = dev_full[A-1:0];
  assign dev_c     = CMP_W'(dev);
  assign step_c    = CMP_W'(cfg.step_thr);
  assign rel_c     = CMP_W'(cfg.release_thr);
  assign gap       = now_r - last_r;

  assign start       = !in_step_r && (dev_c >= step_c) && (gap >= TICK_W'(cfg.min_gap));
  assign release_hit = in_step_r && (dev_c <= rel_c);
  assign in_window   = (gap <= TICK_W'(cfg.stop_gap));

  assign drem_t = {drem_r, dvd_r[NUM_W-1]};
  assign q_bit  = (drem_t >= {1'b0, gap_r});

  assign acc      = {speed_r, 2'b00} + ACC_W'(inst_r);
  assign prod     = acc * DIV5_MUL_W'(DIV5_MUL);
  assign smooth_q = prod[DIV5_SHIFT +: SPEED_W];

  always_comb begin
    if (kill_r) begin
      speed_new = '0;
    end else if (upd_r) begin
      speed_new = smooth_q;
    end else if (first_r) begin
      speed_new = '0;
    end else begin
      speed_new = speed_r;
    end
  end

  assign pop_ready      = (st_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.speed = out_speed_r;

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    az_nxt         = az_r;
    now_nxt        = now_r;
    sum_nxt        = sum_r;
    rem_nxt        = rem_r;
    root_nxt       = root_r;
    gap_nxt        = gap_r;
    dvd_nxt        = dvd_r;
    drem_nxt       = drem_r;
    inst_nxt       = inst_r;
    result_nxt     = result_r;
    upd_nxt        = upd_r;
    first_nxt      = first_r;
    kill_nxt       = kill_r;
    base_nxt       = base_r;
    base_valid_nxt = base_valid_r;
    in_step_nxt    = in_step_r;
    had_step_nxt   = had_step_r;
    last_nxt       = last_r;
    speed_nxt      = speed_r;
    out_valid_nxt  = out_valid_r;
    out_speed_nxt  = out_speed_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (pop_valid) begin
          now_nxt = pop_data[TICK_W-1:0];
          az_nxt  = pop_data[TICK_W +: A];
          ay_nxt  = pop_data[TICK_W + A +: A];
          ax_nxt  = pop_data[TICK_W + 2*A +: A];
          sum_nxt = '0;
          cnt_nxt = '0;
          if (pop_kind == KIND_MEASURE) begin
            st_nxt = ST_SQUARE;
          end else begin
            result_nxt = '0;
            st_nxt     = ST_EMIT;
          end
        end
      end
      ST_SQUARE: begin
        sum_nxt = sum_r + $unsigned(sq);
        if (cnt_r == CNT_W'(2)) begin
          cnt_nxt  = '0;
          rem_nxt  = '0;
          root_nxt = '0;
          st_nxt   = ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        if (rem_t >= trial) begin
          rem_nxt  = REM_W'(rem_t - trial);
          root_nxt = {root_r[A-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_t[REM_W-1:0];
          root_nxt = {root_r[A-2:0], 1'b0};
        end
        sum_nxt = {sum_r[SUM_W-3:0], 2'b00};
        if (cnt_r == CNT_W'(A - 1)) begin
          cnt_nxt = '0;
          st_nxt  = ST_DETECT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DETECT: begin
        if (!base_valid_r) begin
          // seeding word
          base_nxt       = root_r;
          base_valid_nxt = 1'b1;
          result_nxt     = '0;
          st_nxt         = ST_EMIT;
        end else begin
          base_nxt  = base_sum[A-1:0];
          upd_nxt   = 1'b0;
          first_nxt = 1'b0;
          inst_nxt  = SPEED_W'(SPEED_MAX);
          gap_nxt   = gap[GAP_W-1:0];
          dvd_nxt   = NUM_W'(SPEED_NUM);
          drem_nxt  = '0;
          cnt_nxt   = '0;
          st_nxt    = ST_SMOOTH;
          if (start) begin
            last_nxt    = now_r;
            in_step_nxt = 1'b1;
            if (had_step_r) begin
              upd_nxt = in_window;
              if (in_window && (gap > TICK_W'(SAT_GAP))) begin
                st_nxt = ST_DIVIDE;
              end
            end else begin
              had_step_nxt = 1'b1;
              first_nxt    = 1'b1;
            end
          end else if (release_hit) begin
            in_step_nxt = 1'b0;
          end
          // a fresh step has a zero interval
          kill_nxt = start ? (cfg.stop_gap == '0) : (gap >= TICK_W'(cfg.stop_gap));
        end
      end
      ST_DIVIDE: begin
        drem_nxt = q_bit ? GAP_W'(drem_t - {1'b0, gap_r}) : drem_t[GAP_W-1:0];
        dvd_nxt  = {dvd_r[NUM_W-2:0], q_bit};
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          inst_nxt = dvd_nxt[SPEED_W-1:0];
          st_nxt   = ST_SMOOTH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SMOOTH: begin
        speed_nxt  = speed_new;
        result_nxt = speed_new;
        st_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = result_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      cnt_r        <= '0;
      base_r       <= '0;
      base_valid_r <= 1'b0;
      in_step_r    <= 1'b0;
      had_step_r   <= 1'b0;
      last_r       <= '0;
      speed_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      cnt_r        <= cnt_nxt;
      base_r       <= base_nxt;
      base_valid_r <= base_valid_nxt;
      in_step_r    <= in_step_nxt;
      had_step_r   <= had_step_nxt;
      last_r       <= last_nxt;
      speed_r      <= speed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    az_r        <= az_nxt;
    now_r       <= now_nxt;
    sum_r       <= sum_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    gap_r       <= gap_nxt;
    dvd_r       <= dvd_nxt;
    drem_r      <= drem_nxt;
    inst_r      <= inst_nxt;
    result_r    <= result_nxt;
    upd_r       <= upd_nxt;
    first_r     <= first_nxt;
    kill_r      <= kill_nxt;
    out_speed_r <= out_speed_nxt;
  end

endmodule

### rtl/core/accel_step_cadence_speed.sv
// ----------------------------------------------------------------------------
// accel_step_cadence_speed
// Accelerometer step detector with a smoothed running-speed estimate.
// ----------------------------------------------------------------------------
//  channel    dir  carries
//  in_chan    in   accel_x/y/z, sample_ok, now_ms  (one sample word)
//  out_chan   out  speed                           (one word per sample)
//  cfg_chan   in   index, data                     (register write)
//
//  A measured word goes through SQUARE, ROOT, DETECT, SMOOTH and EMIT, with
//  the 15-step DIVIDE after DETECT when the interval needs the divider; the
//  seeding word skips SMOOTH and a zero word goes straight to EMIT. The root
//  unit gives one result bit a cycle. Each word is first held in the queue.
//  Reset is synchronous and clears the detector state and the queue.
//  Intake fills the queue until it is full while a result waits on out_chan.
// ----------------------------------------------------------------------------
module accel_step_cadence_speed import ascs_pkg::*; #(
  parameter int AXIS_BITS   = AXIS_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ascs_in_if.sink    in_chan,
  ascs_out_if.source out_chan,
  ascs_cfg_if.sink   cfg_chan
);

  localparam int ENTRY_W = 1 + 3*AXIS_BITS + TICK_W;

  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_data;
  ascs_cfg_t          cfg;

  ascs_front #(
    .AXIS_BITS (AXIS_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .cfg        (cfg)
  );

  ascs_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ascs_back #(
    .AXIS_BITS (AXIS_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .cfg       (cfg),
    .out_chan  (out_chan)
  );

endmodule

### tb/sv/tb_accel_step_cadence_speed.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_step_cadence_speed
// Self-checking bench for the step detector and running-speed estimator.
// Feeds sample words (directed corners, then walking patterns with noise)
// through several register settings and idling mixes. Every speed word is
// compared against a cycle-free model of baseline tracking, hysteresis,
// step spacing and speed smoothing.
// ----------------------------------------------------------------------------
module tb_accel_step_cadence_speed import ascs_pkg::*;;

  localparam int AXW         = AXIS_BITS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic signed [AXW-1:0] x;
    logic signed [AXW-1:0] y;
    logic signed [AXW-1:0] z;
    logic                  ok;
    logic [TICK_W-1:0]     now;
  } accel_word_t;

  logic clk;
  logic rst_n;

  ascs_in_if #(.AXIS_BITS(AXW)) in_if ();
  ascs_out_if                   out_if ();
  ascs_cfg_if                   cfg_if ();

  accel_step_cadence_speed #(.AXIS_BITS(AXW)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  accel_word_t        sample_pending_q[$];
  logic [SPEED_W-1:0] speed_expected_q[$];
  accel_word_t        word_on_bus;
  logic [SPEED_W-1:0] speed_due;

  // gait model state and its copy of the registers
  ascs_cfg_t         regs_m;
  int                base_mg;
  bit                base_ok;
  bit                stepping;
  bit                stepped;
  logic [TICK_W-1:0] last_step_tick;
  int unsigned       spd_m;

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_go;
  bit          hold_taken = 1'b0;
  int          hold_left  = 0;
  int          err_cnt;
  int          quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [SPEED_W-1:0] predict_speed(input accel_word_t w);
    int unsigned       mag;
    int unsigned       dev;
    int unsigned       inst;
    int                diff;
    logic [TICK_W-1:0] gap;
    if (!regs_m.sensor_present || !w.ok) return '0;
    mag = floor_root(int'(w.x) * int'(w.x) + int'(w.y) * int'(w.y) +
                     int'(w.z) * int'(w.z));
    if (!base_ok) begin
      base_mg = mag;
      base_ok = 1'b1;
      return '0;
    end
    // deviation is taken against the baseline before it moves
    diff    = int'(mag) - base_mg;
    base_mg = base_mg + diff / (1 << BASE_SHIFT);
    dev     = (diff < 0) ? -diff : diff;
    gap     = w.now - last_step_tick;
    if (!stepping && dev >= regs_m.step_thr && gap >= regs_m.min_gap) begin
      if (!stepped) begin
        stepped = 1'b1;
        spd_m   = 0;
      end else if (gap <= regs_m.stop_gap) begin
        inst = (gap == 0) ? SPEED_MAX : SPEED_NUM / gap;
        if (inst > SPEED_MAX) inst = SPEED_MAX;
        spd_m = (spd_m * 4 + inst) / 5;
      end
      last_step_tick = w.now;
      stepping       = 1'b1;
    end else if (stepping && dev <= regs_m.release_thr) begin
      stepping = 1'b0;
    end
    gap = w.now - last_step_tick;
    if (gap >= regs_m.stop_gap) spd_m = 0;
    return spd_m[SPEED_W-1:0];
  endfunction

  function automatic logic signed [AXW-1:0] sat_axis(input int v);
    int top;
    top = (1 << (AXW - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic int rand_sign(input int v);
    return ($urandom_range(0, 1) != 0) ? v : -v;
  endfunction

  function automatic int jitter(input int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic int rand_axis();
    return int'($urandom_range(0, (1 << AXW) - 1)) - (1 << (AXW - 1));
  endfunction

  task automatic push_word(input int x, input int y, input int z, input logic ok,
                           input logic [TICK_W-1:0] now);
    accel_word_t w;
    w.x   = sat_axis(x);
    w.y   = sat_axis(y);
    w.z   = sat_axis(z);
    w.ok  = ok;
    w.now = now;
    sample_pending_q.push_back(w);
  endtask

  // checked between edges, after the driver has settled the bus
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_pending_q.size() != 0 || in_if.valid || speed_expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_SENSOR_PRESENT: regs_m.sensor_present = data[0];
      CFG_STEP_THR:       regs_m.step_thr       = data[THR_W-1:0];
      CFG_RELEASE_THR:    regs_m.release_thr    = data[THR_W-1:0];
      CFG_MIN_GAP:        regs_m.min_gap        = data[GAP_W-1:0];
      CFG_STOP_GAP:       regs_m.stop_gap       = data[GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] rel,
                          input logic [CFG_DATA_W-1:0] min_gap,
                          input logic [CFG_DATA_W-1:0] stop_gap);
    write_reg(CFG_STEP_THR, thr);
    write_reg(CFG_RELEASE_THR, rel);
    write_reg(CFG_MIN_GAP, min_gap);
    write_reg(CFG_STOP_GAP, stop_gap);
  endtask

  // walking pattern: a spike word then a few settled words per stride,
  // stride lengths around the gap registers, with raw noise mixed in
  task automatic gen_walk(input int n_items);
    int                made;
    int                reps;
    int                rest_mg;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       period;
    int unsigned       dt;
    logic [TICK_W-1:0] t;
    made    = 0;
    rest_mg = $urandom_range(1100, 900);
    t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4000) : $urandom;
    while (made < n_items) begin
      case ($urandom_range(0, 19))
        0: begin
          push_word(rand_axis(), rand_axis(), rand_axis(), 1'b0, $urandom);
          made++;
        end
        1, 2: begin
          push_word(rand_axis(), rand_axis(), rand_axis(), 1'b1, t);
          made++;
        end
        3: begin
          t = $urandom;
          push_word(jitter(30), jitter(30), rand_sign(rest_mg + jitter(30)), 1'b1, t);
          made++;
        end
        default: begin
          lo = regs_m.min_gap;
          hi = regs_m.stop_gap;
          case ($urandom_range(0, 9))
            0: period = lo;
            1: period = hi;
            2: period = (lo != 0) ? lo - 1 : 0;
            3: period = hi + 1;
            default: period = $urandom_range(hi + hi / 4 + 1, (lo > 8) ? lo - lo / 8 : 0);
          endcase
          case ($urandom_range(0, 2))
            0: push_word(rand_sign($urandom_range(2047, 800)), rand_sign($urandom_range(2047, 800)),
                         rand_sign(2047), 1'b1, t);
            1: push_word(jitter(60), jitter(60), jitter(60), 1'b1, t);
            default: push_word(jitter(40), jitter(40),
                               rand_sign(rest_mg + int'(regs_m.step_thr) +
                                         int'($urandom_range(0, 150))), 1'b1, t);
          endcase
          reps = $urandom_range(1, 4);
          dt   = period / (reps + 1);
          for (int k = 1; k <= reps; k++)
            push_word(jitter(30), jitter(30), rand_sign(rest_mg + jitter(30)), 1'b1, t + dt * k);
          t    = t + period;
          made = made + reps + 1;
        end
      endcase
    end
  endtask

  task automatic run_phase(input int n_items, input int unsigned send_pct,
                           input int unsigned recv_pct);
    sender_idle_pct = send_pct;
    recv_stall_pct  = recv_pct;
    gen_walk(n_items);
    wait_drained();
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) speed_expected_q.push_back(predict_speed(word_on_bus));
      if (!in_if.valid || in_if.ready) begin
        if (sample_pending_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          word_on_bus = sample_pending_q.pop_front();
          in_if.accel_x   <= word_on_bus.x;
          in_if.accel_y   <= word_on_bus.y;
          in_if.accel_z   <= word_on_bus.z;
          in_if.sample_ok <= word_on_bus.ok;
          in_if.now_ms    <= word_on_bus.now;
          in_if.valid     <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // speed monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (speed_expected_q.size() == 0) begin
          $error("speed word with nothing expected: got %0d", out_if.speed);
          err_cnt++;
        end else begin
          speed_due = speed_expected_q.pop_front();
          if (out_if.speed !== speed_due) begin
            $error("speed mismatch: expected %0d, got %0d", speed_due, out_if.speed);
            err_cnt++;
          end
        end
      end
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: too long without any word moving on any channel
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(in_if.valid && in_if.ready) && !(out_if.valid && out_if.ready) &&
          !(cfg_if.valid && cfg_if.ready))
        quiet++;
      else
        quiet = 0;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] d_thr;
    logic [CFG_DATA_W-1:0] d_rel;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.accel_x   = '0;
    in_if.accel_y   = '0;
    in_if.accel_z   = '0;
    in_if.sample_ok = 1'b0;
    in_if.now_ms    = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    regs_m = '{SENSOR_PRESENT_RST, STEP_THR_RST, RELEASE_THR_RST, MIN_GAP_RST, STOP_GAP_RST};
    base_mg         = 0;
    base_ok         = 1'b0;
    stepping        = 1'b0;
    stepped         = 1'b0;
    last_step_tick  = '0;
    spd_m           = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_go         = 1'b0;
    err_cnt         = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bad read before seeding, seeding, steps, early spike, stop, tick wrap
    push_word(-2048, 2047, -2048, 1'b0, 32'hFFFF_FFFF);
    push_word(0, 0, 1000, 1'b1, 100);
    push_word(0, 0, 1000, 1'b1, 110);
    push_word(0, 0, 2047, 1'b1, 300);
    push_word(0, 0, 1000, 1'b1, 320);
    push_word(2047, -2048, -2048, 1'b1, 500);
    push_word(0, 0, 1000, 1'b1, 510);
    push_word(0, 0, -2048, 1'b1, 700);
    push_word(0, 0, 1000, 1'b1, 710);
    push_word(0, 0, 0, 1'b1, 1000);
    push_word(-2048, -2048, 2047, 1'b0, 1005);
    push_word(0, 0, 1000, 1'b1, 1010);
    push_word(0, 0, 1000, 1'b1, 3000);
    push_word(0, 0, 0, 1'b1, 32'hFFFF_FF00);
    push_word(0, 0, 1000, 1'b1, 32'hFFFF_FF80);
    push_word(0, 0, 2047, 1'b1, 32'h0000_0100);
    push_word(0, 0, 1000, 1'b1, 32'h0000_0110);
    wait_drained();

    // zero interval: two steps on the same tick
    write_reg(CFG_MIN_GAP, 16'd0);
    push_word(0, 0, 0, 1'b1, 6000);
    push_word(0, 0, 1000, 1'b1, 6000);
    push_word(0, 0, 0, 1'b1, 6000);
    push_word(0, 0, 1000, 1'b1, 6000);
    wait_drained();

    // sensor absent, written with stray upper bits that must be dropped
    write_reg(CFG_SENSOR_PRESENT, 16'hFFFE);
    push_word(0, 0, 0, 1'b1, 7000);
    push_word(0, 0, 1000, 1'b1, 7400);
    wait_drained();
    write_reg(CFG_SENSOR_PRESENT, 16'h0001);
    for (int i = CFG_STOP_GAP + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));

    set_regs(300, 150, 250, 2000);
    run_phase(200, 0, 0);
    set_regs(200, 100, 100, 1000);
    run_phase(200, 71, 0);
    set_regs(500, 300, 300, 3000);
    run_phase(200, 0, 71);
    set_regs(0, 0, 1, 1);
    run_phase(150, 36, 36);
    set_regs(4095, 4095, 65535, 65535);
    run_phase(60, 0, 0);

    d_thr        = CFG_DATA_W'($urandom);
    d_thr[11:0]  = THR_W'($urandom_range(700, 100));
    d_rel        = CFG_DATA_W'($urandom);
    d_rel[11:0]  = THR_W'($urandom_range(200, 0));
    set_regs(d_thr, d_rel, CFG_DATA_W'($urandom_range(400, 1)),
             CFG_DATA_W'($urandom_range(5000, 400)));
    run_phase(150, 36, 36);

    // receiver holds off while the sender keeps offering, so intake backs up
    set_regs(300, 150, 250, 2000);
    hold_go = 1'b1;
    run_phase(120, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (speed_expected_q.size() != 0) begin
      $error("%0d speed words never arrived", speed_expected_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ascs_pkg.sv
rtl/core/ascs_if.sv
rtl/core/ascs_front.sv
rtl/core/ascs_queue.sv
rtl/core/ascs_back.sv
rtl/core/accel_step_cadence_speed.sv
tb/sv/tb_accel_step_cadence_speed.sv
